### hw/rtl/gng_pkg.sv
// Shared types, constants and offset table for the grid neighbour generator.
`default_nettype none

package gng_pkg;

    localparam int COORD_BITS_DEF  = 12;
    localparam int CFG_SIZE_BITS   = 13;
    localparam int MODE_BITS       = 2;
    localparam int NB_SLOTS        = 8;
    localparam int SLOT_BITS       = 3;
    localparam int QUEUE_DEPTH     = 2;
    localparam int APB_ADDR_BITS   = 4;
    localparam int APB_DATA_BITS   = 32;

    localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [1:0] REG_NB_MODE     = 2'd2;

    localparam logic [MODE_BITS-1:0] MODE_FOUR     = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_EIGHT    = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_WEIGHTED = 2'd2;

    localparam logic [1:0] WEIGHT_ONE = 2'd1;
    localparam logic [1:0] WEIGHT_TWO = 2'd2;

    typedef struct packed {
        logic [CFG_SIZE_BITS-1:0] grid_width;
        logic [CFG_SIZE_BITS-1:0] grid_height;
        logic [MODE_BITS-1:0]     mode;
    } gng_cfg_t;

    typedef enum logic [1:0] {
        STEP_DEC,
        STEP_KEEP,
        STEP_INC
    } step_t;

    typedef struct packed {
        step_t dx;
        step_t dy;
        logic  orth;
    } nb_offset_t;

    function automatic nb_offset_t nb_offset(input logic four, input logic [SLOT_BITS-1:0] slot);
        nb_offset_t off;
        off = '{dx: STEP_KEEP, dy: STEP_KEEP, orth: 1'b0};
        unique case ({four, slot})
            4'b1_000: off = '{dx: STEP_DEC,  dy: STEP_KEEP, orth: 1'b1};
            4'b1_001: off = '{dx: STEP_INC,  dy: STEP_KEEP, orth: 1'b1};
            4'b1_010: off = '{dx: STEP_KEEP, dy: STEP_DEC,  orth: 1'b1};
            4'b1_011: off = '{dx: STEP_KEEP, dy: STEP_INC,  orth: 1'b1};
            4'b0_000: off = '{dx: STEP_DEC,  dy: STEP_DEC,  orth: 1'b0};
            4'b0_001: off = '{dx: STEP_KEEP, dy: STEP_DEC,  orth: 1'b1};
            4'b0_010: off = '{dx: STEP_INC,  dy: STEP_DEC,  orth: 1'b0};
            4'b0_011: off = '{dx: STEP_DEC,  dy: STEP_KEEP, orth: 1'b1};
            4'b0_100: off = '{dx: STEP_INC,  dy: STEP_KEEP, orth: 1'b1};
            4'b0_101: off = '{dx: STEP_DEC,  dy: STEP_INC,  orth: 1'b0};
            4'b0_110: off = '{dx: STEP_KEEP, dy: STEP_INC,  orth: 1'b1};
            4'b0_111: off = '{dx: STEP_INC,  dy: STEP_INC,  orth: 1'b0};
            default:  off = '{dx: STEP_KEEP, dy: STEP_KEEP, orth: 1'b0};
        endcase
        return off;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/gng_regs.sv
// APB configuration registers: grid width, grid height and neighbourhood mode.
`default_nettype none

module gng_regs
    import gng_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [APB_ADDR_BITS-1:0] paddr,
    input  wire logic [APB_DATA_BITS-1:0] pwdata,
    output logic      [APB_DATA_BITS-1:0] prdata,
    output logic                          pready,
    output gng_cfg_t                      cfg
);

    gng_cfg_t   cfg_reg;
    gng_cfg_t   cfg_next;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_GRID_WIDTH:  cfg_next.grid_width  = pwdata[CFG_SIZE_BITS-1:0];
                REG_GRID_HEIGHT: cfg_next.grid_height = pwdata[CFG_SIZE_BITS-1:0];
                REG_NB_MODE:     cfg_next.mode        = pwdata[MODE_BITS-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_GRID_WIDTH:  prdata = APB_DATA_BITS'(cfg_reg.grid_width);
            REG_GRID_HEIGHT: prdata = APB_DATA_BITS'(cfg_reg.grid_height);
            REG_NB_MODE:     prdata = APB_DATA_BITS'(cfg_reg.mode);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.grid_width  <= CFG_SIZE_BITS'(1);
            cfg_reg.grid_height <= CFG_SIZE_BITS'(1);
            cfg_reg.mode        <= MODE_FOUR;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/gng_front.sv
// Front stage: accept a position beat and classify which neighbour slots lie in bounds.
`default_nettype none

module gng_front
    import gng_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int TDATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8,
    parameter int ENTRY_BITS = 2 * COORD_BITS + NB_SLOTS + MODE_BITS
)
(
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [TDATA_BITS-1:0] s_axis_tdata,
    input  wire gng_cfg_t              cfg,
    input  wire logic                  q_full,
    output logic                       q_push,
    output logic      [ENTRY_BITS-1:0] q_wdata
);

    localparam int CW = (COORD_BITS > CFG_SIZE_BITS ? COORD_BITS : CFG_SIZE_BITS) + 2;
    localparam logic [CW-1:0] SIZE_LIM = CW'(1) << COORD_BITS;

    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
    logic [CW-1:0]         w_ext;
    logic [CW-1:0]         h_ext;
    logic [CW-1:0]         wc;
    logic [CW-1:0]         hc;
    logic [CW-1:0]         px_e;
    logic [CW-1:0]         py_e;
    logic [CW-1:0]         px1;
    logic [CW-1:0]         py1;
    logic                  col_m;
    logic                  col_0;
    logic                  col_p;
    logic                  row_m;
    logic                  row_0;
    logic                  row_p;
    logic [NB_SLOTS-1:0]   mask;

    assign pos_x = s_axis_tdata[COORD_BITS-1:0];
    assign pos_y = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];

    assign w_ext = CW'(cfg.grid_width);
    assign h_ext = CW'(cfg.grid_height);
    assign wc    = (w_ext > SIZE_LIM) ? SIZE_LIM : w_ext;
    assign hc    = (h_ext > SIZE_LIM) ? SIZE_LIM : h_ext;
    assign px_e  = CW'(pos_x);
    assign py_e  = CW'(pos_y);
    assign px1   = px_e + CW'(1);
    assign py1   = py_e + CW'(1);

    assign col_m = (pos_x != '0) && (px_e <= wc);
    assign col_0 = px_e < wc;
    assign col_p = px1 < wc;
    assign row_m = (pos_y != '0) && (py_e <= hc);
    assign row_0 = py_e < hc;
    assign row_p = py1 < hc;

    always_comb
    begin
        case (cfg.mode)
            MODE_FOUR:
                mask = {4'b0000, py1 < hc, pos_y != '0, px1 < wc, pos_x != '0};
            MODE_EIGHT, MODE_WEIGHTED:
                mask = {col_p & row_p, col_0 & row_p, col_m & row_p, col_p & row_0,
                        col_m & row_0, col_p & row_m, col_0 & row_m, col_m & row_m};
            default:
                mask = '0;
        endcase
    end

    // drop positions with no neighbour in bounds
    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && s_axis_tready && (mask != '0);
    assign q_wdata       = {cfg.mode, mask, pos_y, pos_x};

endmodule

`default_nettype wire

### hw/rtl/gng_queue.sv
// Short queue of classified positions between the front and back stages.
`default_nettype none

module gng_queue
#(
    parameter int WIDTH = 34,
    parameter int DEPTH = 2
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic                  valid,
    output logic      [WIDTH-1:0] rdata
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [CNTW-1:0]  count_reg;
    logic [CNTW-1:0]  count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = count_reg == CNTW'(DEPTH);
    assign valid   = count_reg != '0;
    assign rdata   = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNTW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNTW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/gng_back.sv
// Back stage: walk a position's in-bounds slots, one neighbour beat per cycle unless stalled.
`default_nettype none

module gng_back
    import gng_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int TDATA_BITS = ((2 * COORD_BITS + 2 + 7) / 8) * 8,
    parameter int ENTRY_BITS = 2 * COORD_BITS + NB_SLOTS + MODE_BITS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  q_valid,
    input  wire logic [ENTRY_BITS-1:0] q_rdata,
    output logic                       q_pop,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic      [TDATA_BITS-1:0] m_axis_tdata,
    output logic                       m_axis_tlast
);

    logic                  cur_valid_reg;
    logic                  cur_valid_next;
    logic [NB_SLOTS-1:0]   cur_mask_reg;
    logic [NB_SLOTS-1:0]   cur_mask_next;
    logic [COORD_BITS-1:0] cur_px_reg;
    logic [COORD_BITS-1:0] cur_px_next;
    logic [COORD_BITS-1:0] cur_py_reg;
    logic [COORD_BITS-1:0] cur_py_next;
    logic [MODE_BITS-1:0]  cur_mode_reg;
    logic [MODE_BITS-1:0]  cur_mode_next;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [COORD_BITS-1:0] out_x_reg;
    logic [COORD_BITS-1:0] out_y_reg;
    logic [1:0]            out_weight_reg;
    logic                  out_last_reg;

    logic [SLOT_BITS-1:0]  slot;
    logic [NB_SLOTS-1:0]   slot_bit;
    logic [NB_SLOTS-1:0]   rest;
    logic                  is_last;
    logic                  load;
    nb_offset_t            off;
    logic [COORD_BITS-1:0] nb_x;
    logic [COORD_BITS-1:0] nb_y;
    logic [1:0]            weight;

    logic [COORD_BITS-1:0] q_px;
    logic [COORD_BITS-1:0] q_py;
    logic [NB_SLOTS-1:0]   q_mask;
    logic [MODE_BITS-1:0]  q_mode;

    assign {q_mode, q_mask, q_py, q_px} = q_rdata;

    // pick the lowest pending slot
    always_comb
    begin
        slot = '0;
        for (int i = NB_SLOTS - 1; i >= 0; i--)
        begin
            if (cur_mask_reg[i])
            begin
                slot = SLOT_BITS'(i);
            end
        end
    end

    assign slot_bit = NB_SLOTS'(1) << slot;
    assign rest     = cur_mask_reg & ~slot_bit;
    assign is_last  = rest == '0;
    assign off      = nb_offset(cur_mode_reg == MODE_FOUR, slot);

    always_comb
    begin
        case (off.dx)
            STEP_DEC: nb_x = cur_px_reg - COORD_BITS'(1);
            STEP_INC: nb_x = cur_px_reg + COORD_BITS'(1);
            default:  nb_x = cur_px_reg;
        endcase
        case (off.dy)
            STEP_DEC: nb_y = cur_py_reg - COORD_BITS'(1);
            STEP_INC: nb_y = cur_py_reg + COORD_BITS'(1);
            default:  nb_y = cur_py_reg;
        endcase
    end

    assign weight = (cur_mode_reg == MODE_WEIGHTED && off.orth) ? WEIGHT_TWO : WEIGHT_ONE;

    assign load  = cur_valid_reg && (!out_valid_reg || m_axis_tready);
    assign q_pop = q_valid && (!cur_valid_reg || (load && is_last));

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cur_mask_next  = cur_mask_reg;
        cur_px_next    = cur_px_reg;
        cur_py_next    = cur_py_reg;
        cur_mode_next  = cur_mode_reg;
        if (q_pop)
        begin
            cur_valid_next = 1'b1;
            cur_mask_next  = q_mask;
            cur_px_next    = q_px;
            cur_py_next    = q_py;
            cur_mode_next  = q_mode;
        end
        else if (load)
        begin
            cur_valid_next = !is_last;
            cur_mask_next  = rest;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_mask_reg <= cur_mask_next;
        cur_px_reg   <= cur_px_next;
        cur_py_reg   <= cur_py_next;
        cur_mode_reg <= cur_mode_next;
        if (load)
        begin
            out_x_reg      <= nb_x;
            out_y_reg      <= nb_y;
            out_weight_reg <= weight;
            out_last_reg   <= is_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = TDATA_BITS'({out_weight_reg, out_y_reg, out_x_reg});
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

### hw/rtl/grid_neighbour_generator_top.sv
// Top level of the grid neighbour generator.
`default_nettype none

// Each accepted position yields its in-bounds grid neighbours (four-connected, eight-connected
// or eight-connected weighted, set by the mode register) as one beat per neighbour, the final
// beat carrying tlast; a position with no neighbour in bounds, and any position in mode 3,
// yields no beat. The back stage emits one neighbour per cycle while the output is not stalled;
// a position has 1 to 8 neighbours in bounds (8 at most in the eight-connected modes). Input
// beats are taken at one per cycle while the two-entry position queue has room, and each
// position passes through the queue entry, the back stage's current-position registers and
// the output register. Write the configuration only while no results are outstanding.
module grid_neighbour_generator_top
    import gng_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic                                        clk,
    input  wire logic                                        rst_n,
    // APB configuration
    input  wire logic                                        psel,
    input  wire logic                                        penable,
    input  wire logic                                        pwrite,
    input  wire logic [APB_ADDR_BITS-1:0]                    paddr,
    input  wire logic [APB_DATA_BITS-1:0]                    pwdata,
    output logic      [APB_DATA_BITS-1:0]                    prdata,
    output logic                                             pready,
    // positions
    input  wire logic                                        s_axis_tvalid,
    output logic                                             s_axis_tready,
    // pos_x, pos_y, zero pad
    input  wire logic [((2*COORD_BITS+7)/8)*8-1:0]           s_axis_tdata,
    // neighbours
    output logic                                             m_axis_tvalid,
    input  wire logic                                        m_axis_tready,
    // nb_x, nb_y, weight, zero pad
    output logic      [((2*COORD_BITS+2+7)/8)*8-1:0]         m_axis_tdata,
    output logic                                             m_axis_tlast
);

    localparam int IN_BITS    = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = ((2 * COORD_BITS + 2 + 7) / 8) * 8;
    localparam int ENTRY_BITS = 2 * COORD_BITS + NB_SLOTS + MODE_BITS;

    gng_cfg_t              cfg;
    logic                  q_push;
    logic [ENTRY_BITS-1:0] q_wdata;
    logic                  q_full;
    logic                  q_pop;
    logic                  q_valid;
    logic [ENTRY_BITS-1:0] q_rdata;

    gng_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gng_front #(
        .COORD_BITS (COORD_BITS),
        .TDATA_BITS (IN_BITS),
        .ENTRY_BITS (ENTRY_BITS)
    ) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .cfg           (cfg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_wdata       (q_wdata)
    );

    gng_queue #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .valid (q_valid),
        .rdata (q_rdata)
    );

    gng_back #(
        .COORD_BITS (COORD_BITS),
        .TDATA_BITS (OUT_BITS),
        .ENTRY_BITS (ENTRY_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_rdata       (q_rdata),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

### hw/rtl/gng_checker.sv
// Port-level checker for the grid neighbour generator and its bind to the top level.
`default_nettype none

module gng_checker
    import gng_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                psel,
    input wire logic                                penable,
    input wire logic                                pwrite,
    input wire logic [APB_ADDR_BITS-1:0]            paddr,
    input wire logic [APB_DATA_BITS-1:0]            pwdata,
    input wire logic [APB_DATA_BITS-1:0]            prdata,
    input wire logic                                pready,
    input wire logic                                m_axis_tvalid,
    input wire logic                                m_axis_tready,
    input wire logic [((2*COORD_BITS+2+7)/8)*8-1:0] m_axis_tdata,
    input wire logic                                m_axis_tlast
);

    logic [1:0] out_weight;

    assign out_weight = m_axis_tdata[2*COORD_BITS+1:2*COORD_BITS];

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result beat changed while stalled");

    a_weight: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (out_weight == WEIGHT_ONE || out_weight == WEIGHT_TWO))
        else $error("neighbour weight out of range");

    a_width_readback: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) && $past(psel && penable && pwrite && pready && paddr[3:2] == REG_GRID_WIDTH)
        && psel && !pwrite && paddr[3:2] == REG_GRID_WIDTH
        |-> prdata[CFG_SIZE_BITS-1:0] == $past(pwdata[CFG_SIZE_BITS-1:0]))
        else $error("grid width readback mismatch");

endmodule

bind grid_neighbour_generator_top gng_checker #(.COORD_BITS(COORD_BITS)) u_gng_checker (.*);

`default_nettype wire
